// File: hdl/rvq_pkg.sv
// ----------------------------------------------------------------------------
// rvq_pkg
// Shared widths, constants, types and elaboration helpers for the rotation
// vector to quaternion core.
// ----------------------------------------------------------------------------
package rvq_pkg;

	localparam int MAG_W  = 32;
	localparam int SQ_W   = 64;
	localparam int TH_W   = 32;
	localparam int ISQ_N  = 32;
	localparam int ANG_W  = 36;
	localparam int SMAG_W = 33;
	localparam int NUM_W  = 64;
	localparam int DEN_W  = 34;
	localparam int QUO_W  = 31;
	localparam int OUT_W  = 32;
	localparam int ATAN_N = 48;

	localparam logic [ANG_W-1:0] PI4_U    = 36'd3373259426;
	localparam logic [ANG_W-1:0] HALFPI_U = 36'd6746518852;
	localparam logic signed [ANG_W-1:0] QONE = 36'sd1073741824;

	// atan(2^-i) at 2^-32
	localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
		32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
		32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
		32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
		32'd1048576,    32'd524288,     32'd262144,     32'd131072,
		32'd65536,      32'd32768,      32'd16384,      32'd8192,
		32'd4096,       32'd2048,       32'd1024,       32'd512,
		32'd256,        32'd128,        32'd64,         32'd32,
		32'd16,         32'd8,          32'd4,          32'd2,
		32'd1,          32'd1,          32'd0,          32'd0,
		32'd0,          32'd0,          32'd0,          32'd0,
		32'd0,          32'd0,          32'd0,          32'd0,
		32'd0,          32'd0,          32'd0,          32'd0
	};

	typedef struct packed {
		logic                  tiny;
		logic [2:0]            neg;
		logic [2:0][MAG_W-1:0] mag;
	} rvq_side_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] w;
		logic                    sneg;
		logic [SMAG_W-1:0]       smag;
	} rvq_cs_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] r;
		logic [63:0] bitv;
		rem  = v;
		r    = '0;
		bitv = 64'h4000_0000_0000_0000;
		for (int k = 0; k < 32; k++) begin
			if (rem >= r + bitv) begin
				rem = rem - (r + bitv);
				r   = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] gain_root(input int stages);
		logic [63:0] p;
		p = 64'h8000_0000_0000_0000;
		for (int i = 1; i < 32; i++) begin
			if (i < stages)
				p = p + (p >> (2 * i));
		end
		return isqrt64(p);
	endfunction

endpackage

// File: hdl/rvq_cordic.sv
// ----------------------------------------------------------------------------
// rvq_cordic
// Half-angle range reduction, rotation-mode CORDIC and quadrant fold.
// ----------------------------------------------------------------------------
module rvq_cordic import rvq_pkg::*; #(
	parameter int STAGES = 32
) (
	input  logic            clk,
	input  logic [TH_W-1:0] theta,
	output rvq_cs_t         cs
);

	localparam logic [63:0] GAIN_FULL = 64'h8000_0000_0000_0000 / gain_root(STAGES);
	localparam logic signed [ANG_W-1:0] GAIN = signed'(GAIN_FULL[ANG_W-1:0]);

	logic [ANG_W-1:0] h;
	logic [ANG_W-1:0] v;
	logic [ANG_W-1:0] off;
	logic [2:0]       q;

	logic signed [ANG_W-1:0] cx_s [STAGES+1];
	logic signed [ANG_W-1:0] cy_s [STAGES+1];
	logic signed [ANG_W-1:0] cz_s [STAGES+1];
	logic [1:0]              cq_s [STAGES+1];

	assign h = {1'b0, theta, 3'b000};
	assign v = h + PI4_U;

	always_comb begin
		q = 3'd0;
		for (int k = 1; k <= 4; k++) begin
			if (v >= ANG_W'(k) * HALFPI_U)
				q = 3'(k);
		end
	end

	always_comb begin
		case (q)
			3'd1:    off = HALFPI_U;
			3'd2:    off = ANG_W'(2) * HALFPI_U;
			3'd3:    off = ANG_W'(3) * HALFPI_U;
			3'd4:    off = ANG_W'(4) * HALFPI_U;
			default: off = '0;
		endcase
	end

	assign cx_s[0] = GAIN;
	assign cy_s[0] = '0;

	always_ff @(posedge clk) begin
		cz_s[0] <= signed'(h - off);
		cq_s[0] <= q[1:0];
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic signed [ANG_W-1:0] ANG = signed'({4'b0000, ATAN_TAB[i]});
		always_ff @(posedge clk) begin
			if (cz_s[i] >= 0) begin
				cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] - ANG;
			end else begin
				cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] + ANG;
			end
			cq_s[i+1] <= cq_s[i];
		end
	end

	logic signed [ANG_W-1:0] c;
	logic signed [ANG_W-1:0] s;
	logic signed [ANG_W-1:0] t;
	logic signed [ANG_W-1:0] wc;
	logic [ANG_W-1:0]        sa;
	logic [SMAG_W-1:0]       sm;

	always_comb begin
		case (cq_s[STAGES])
			2'd0:    begin c = cx_s[STAGES];  s = cy_s[STAGES];  end
			2'd1:    begin c = -cy_s[STAGES]; s = cx_s[STAGES];  end
			2'd2:    begin c = -cx_s[STAGES]; s = -cy_s[STAGES]; end
			default: begin c = cy_s[STAGES];  s = -cx_s[STAGES]; end
		endcase
		t = (c + 36'sd2) >>> 2;
		if (t > QONE)
			wc = QONE;
		else if (t < -QONE)
			wc = -QONE;
		else
			wc = t;
		sa = (s < 0) ? unsigned'(-s) : unsigned'(s);
		if (sa > 36'h1_0000_0000)
			sm = 33'h1_0000_0000;
		else
			sm = sa[SMAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		cs.w    <= wc[OUT_W-1:0];
		cs.sneg <= (s < 0);
		cs.smag <= sm;
	end

endmodule

// File: hdl/rvq_div.sv
// ----------------------------------------------------------------------------
// rvq_div
// Pipelined restoring divider, one quotient bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module rvq_div import rvq_pkg::*; (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	logic [NUM_W-1:0] rem_s [QUO_W+1];
	logic [DEN_W-1:0] den_s [QUO_W+1];
	logic [QUO_W-1:0] quo_s [QUO_W+1];

	always_ff @(posedge clk) begin
		rem_s[0] <= num + {{(NUM_W-DEN_W+1){1'b0}}, den[DEN_W-1:1]};
		den_s[0] <= den;
		quo_s[0] <= '0;
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_bit
		localparam int SH = QUO_W - 1 - k;
		logic [NUM_W:0] dsh;
		logic           ge;
		assign dsh = {{(NUM_W+1-DEN_W){1'b0}}, den_s[k]} << SH;
		assign ge  = ({1'b0, rem_s[k]} >= dsh);
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? (rem_s[k] - dsh[NUM_W-1:0]) : rem_s[k];
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge};
		end
	end

	assign quo = quo_s[QUO_W];

endmodule

// File: hdl/rotation_vector_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// rotation_vector_to_quaternion_core
// Exponential map: rotation vector (Q3.28) to unit quaternion (Q1.30).
//
//   channel   ports                                   transfer
//   input     start, busy, omega_x/y/z                start & !busy
//   result    done, quat_w/x/y/z                      done, one cycle
//   config    cfg_we, cfg_data (small_angle_limit)    cfg_we
//
// One vector per cycle; busy stays low. The pipeline holds these registers:
// 32 square-root stages, CORDIC_STAGES + 2 for the CORDIC, 32 for the divider,
// plus input, square, sum, multiply and output registers.
// Reset clears valid bits and sets the limit to 3. Results cannot be stalled.
// ----------------------------------------------------------------------------
module rotation_vector_to_quaternion_core import rvq_pkg::*; #(
	parameter int CORDIC_STAGES = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [31:0]      omega_x,
	input  logic signed [31:0]      omega_y,
	input  logic signed [31:0]      omega_z,
	input  logic                    cfg_we,
	input  logic [7:0]              cfg_data,
	output logic                    done,
	output logic signed [OUT_W-1:0] quat_w,
	output logic signed [OUT_W-1:0] quat_x,
	output logic signed [OUT_W-1:0] quat_y,
	output logic signed [OUT_W-1:0] quat_z
);

	localparam int CL  = CORDIC_STAGES + 2;
	localparam int DL  = QUO_W + 1;
	localparam int SL  = ISQ_N + CL + DL + 2;
	localparam int LAT = SL + 3;

	logic [7:0] lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= 8'd3;
		end else if (cfg_we) begin
			lim_q <= cfg_data;
		end
	end

	assign busy = 1'b0;

	logic [2:0][31:0] om;
	assign om = {omega_z, omega_y, omega_x};

	logic                  vld_s1, vld_s2;
	logic [2:0]            neg_s1, neg_s2;
	logic [2:0][MAG_W-1:0] mag_s1, mag_s2;
	logic [2:0][SQ_W-1:0]  sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			neg_s1[j] <= om[j][31];
			mag_s1[j] <= om[j][31] ? (~om[j] + 32'd1) : om[j];
			neg_s2[j] <= neg_s1[j];
			mag_s2[j] <= mag_s1[j];
			sq_s2[j]  <= SQ_W'(mag_s1[j]) * SQ_W'(mag_s1[j]);
		end
	end

	// s3: sum of squares and small-angle decision
	logic [SQ_W-1:0] sum;
	logic [15:0]     lim_sq;
	rvq_side_t       side_s [SL];
	logic [SL-1:0]   side_vld_s;
	logic [SQ_W-1:0] rt_v [ISQ_N+1];
	logic [SQ_W-1:0] rt_r [ISQ_N+1];

	assign sum    = sq_s2[0] + sq_s2[1] + sq_s2[2];
	assign lim_sq = 16'(lim_q) * 16'(lim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_vld_s <= '0;
		end else begin
			side_vld_s <= {side_vld_s[SL-2:0], vld_s2};
		end
	end

	always_ff @(posedge clk) begin
		side_s[0].tiny <= (sum == '0) || (sum < {48'd0, lim_sq});
		side_s[0].neg  <= neg_s2;
		side_s[0].mag  <= mag_s2;
		for (int k = 1; k < SL; k++) begin
			side_s[k].tiny <= side_s[k-1].tiny;
			side_s[k].neg  <= side_s[k-1].neg;
			side_s[k].mag  <= side_s[k-1].mag;
		end
		rt_v[0] <= sum;
	end

	// square root, one result bit per stage
	assign rt_r[0] = '0;

	for (genvar k = 0; k < ISQ_N; k++) begin : g_isq
		localparam logic [SQ_W-1:0] BITC = 64'd1 << (62 - 2 * k);
		logic [SQ_W-1:0] trial;
		assign trial = rt_r[k] + BITC;
		always_ff @(posedge clk) begin
			if (rt_v[k] >= trial) begin
				rt_v[k+1] <= rt_v[k] - trial;
				rt_r[k+1] <= (rt_r[k] >> 1) + BITC;
			end else begin
				rt_v[k+1] <= rt_v[k];
				rt_r[k+1] <= rt_r[k] >> 1;
			end
		end
	end

	rvq_cs_t cs;

	rvq_cordic #(
		.STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk  (clk),
		.theta(rt_r[ISQ_N][TH_W-1:0]),
		.cs   (cs)
	);

	logic [TH_W-1:0] thd_s [CL];
	rvq_cs_t         wd_s  [DL+1];

	always_ff @(posedge clk) begin
		thd_s[0] <= rt_r[ISQ_N][TH_W-1:0];
		for (int k = 1; k < CL; k++)
			thd_s[k] <= thd_s[k-1];
		wd_s[0] <= cs;
		for (int k = 1; k <= DL; k++)
			wd_s[k] <= wd_s[k-1];
	end

	// multiply |sin| by |omega_i|
	logic [2:0][SMAG_W+MAG_W-1:0] prd_s;
	logic [DEN_W-1:0]             den_s;

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++)
			prd_s[j] <= cs.smag * side_s[ISQ_N+CL].mag[j];
		den_s <= {thd_s[CL-1], 2'b00};
	end

	logic [2:0][QUO_W-1:0] qd;

	for (genvar j = 0; j < 3; j++) begin : g_div
		rvq_div u_div (
			.clk(clk),
			.num(prd_s[j][NUM_W-1:0]),
			.den(den_s),
			.quo(qd[j])
		);
	end

	rvq_side_t               fin;
	logic [2:0][OUT_W-1:0]   vec;
	logic [OUT_W-1:0]        qv;
	logic [MAG_W:0]          omv;

	assign fin = side_s[SL-1];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			qv = (qd[j] > 31'h4000_0000) ? 32'h4000_0000 : {1'b0, qd[j]};
			omv = fin.neg[j] ? (~{1'b0, fin.mag[j]} + 33'd1) : {1'b0, fin.mag[j]};
			if (fin.tiny)
				vec[j] = {omv[OUT_W-2:0], 1'b0};
			else if (wd_s[DL].sneg ^ fin.neg[j])
				vec[j] = ~qv + 32'd1;
			else
				vec[j] = qv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= side_vld_s[SL-1];
		end
	end

	always_ff @(posedge clk) begin
		quat_w <= fin.tiny ? 32'sh4000_0000 : wd_s[DL].w;
		quat_x <= signed'(vec[0]);
		quat_y <= signed'(vec[1]);
		quat_z <= signed'(vec[2]);
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing after accepted transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without accepted transfer");

	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (quat_w <= 32'sh4000_0000) && (quat_w >= -32'sh4000_0000))
		else $error("quat_w out of range");

endmodule
